[sv/pinit_pkg.sv]
package pinit_pkg;

    // Configuration port geometry: one 32-bit register per word
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [CFG_ADDR_W-3:0] REG_PANEL_FORMAT = '0;

    // Job queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Frame bytes
    localparam logic [7:0] PFX_SEL_HIGH   = 8'h20;
    localparam logic [7:0] PFX_SEL_LOW    = 8'h00;
    localparam logic [7:0] PFX_WRITE      = 8'h40;
    localparam logic [7:0] PFX_READ       = 8'hC0;
    localparam logic [7:0] READ_FILL      = 8'hFF;
    localparam logic [7:0] SHORT_ADDR_BIT = 8'h40;

    localparam logic CMD_LIST = 1'b0;
    localparam logic CMD_READ = 1'b1;
    localparam logic FMT_LONG  = 1'b0;
    localparam logic FMT_SHORT = 1'b1;

    typedef struct packed {
        logic        command;
        logic [7:0]  list_byte;
        logic [15:0] read_address;
    } cmd_item_t;

    typedef struct packed {
        logic       frame_valid;
        logic [7:0] frame_first;
        logic [7:0] frame_second;
        logic       capture_reply;
        logic       list_end;
        logic       last;
    } res_item_t;

    typedef enum logic [1:0] {
        PH_HIGH,
        PH_LOW,
        PH_COUNT,
        PH_DATA
    } parse_phase_t;

    typedef enum logic [2:0] {
        OP_END,
        OP_SEL,
        OP_WR3,
        OP_RD3,
        OP_WR1,
        OP_RD1
    } job_op_t;

    typedef struct packed {
        job_op_t     op;
        logic [15:0] address;
        logic [7:0]  data;
    } job_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

    function automatic logic [7:0] short_address(input logic [7:0] lo);
        return lo + (lo & SHORT_ADDR_BIT);
    endfunction

    function automatic logic [1:0] job_last_index(input job_op_t op);
        logic [1:0] n;
        case (op)
            OP_SEL:          n = 2'd1;
            OP_WR3, OP_RD3:  n = 2'd2;
            default:         n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic res_item_t build_frame(input job_t job, input logic [1:0] idx);
        res_item_t  r;
        logic [7:0] sa;
        sa            = short_address(job.address[7:0]);
        r             = '0;
        r.frame_valid = 1'b1;
        r.last        = (idx == job_last_index(job.op));
        case (job.op)
            OP_END:
            begin
                r.frame_valid = 1'b0;
                r.list_end    = 1'b1;
            end
            OP_WR1:
            begin
                r.frame_first  = sa;
                r.frame_second = job.data;
            end
            OP_RD1:
            begin
                r.frame_first   = sa | SHORT_ADDR_BIT;
                r.frame_second  = READ_FILL;
                r.capture_reply = 1'b1;
            end
            OP_SEL, OP_WR3, OP_RD3:
            begin
                case (idx)
                    2'd0:
                    begin
                        r.frame_first  = PFX_SEL_HIGH;
                        r.frame_second = job.address[15:8];
                    end
                    2'd1:
                    begin
                        r.frame_first  = PFX_SEL_LOW;
                        r.frame_second = job.address[7:0];
                    end
                    default:
                    begin
                        if (job.op == OP_RD3)
                        begin
                            r.frame_first   = PFX_READ;
                            r.frame_second  = READ_FILL;
                            r.capture_reply = 1'b1;
                        end
                        else
                        begin
                            r.frame_first  = PFX_WRITE;
                            r.frame_second = job.data;
                        end
                    end
                endcase
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

endpackage

[sv/pinit_queue.sv]
module pinit_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pinit_pkg::job_t   push_job,
    input  logic              pop,
    output pinit_pkg::job_t   pop_job,
    output pinit_pkg::q_status_t status
);
    import pinit_pkg::*;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign status.full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.not_empty = (count_reg != '0);
    assign pop_job          = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[sv/pinit_front.sv]
module pinit_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 panel_format,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  pinit_pkg::cmd_item_t cmd,
    input  pinit_pkg::q_status_t q_status,
    output logic                 push,
    output pinit_pkg::job_t      push_job
);
    import pinit_pkg::*;

    parse_phase_t phase_reg, phase_next;
    logic [7:0]   addr_hi_reg, addr_hi_next;
    logic [15:0]  cur_addr_reg, cur_addr_next;
    logic [7:0]   remaining_reg, remaining_next;
    logic         accept;
    logic         list_step;

    assign cmd_ready = !q_status.full;
    assign accept    = cmd_valid && cmd_ready;
    assign list_step = accept && (cmd.command == CMD_LIST);

    // Next parse phase
    always_comb
    begin
        phase_next = phase_reg;
        if (list_step)
        begin
            case (phase_reg)
                PH_HIGH:  phase_next = PH_LOW;
                PH_LOW:   phase_next = PH_COUNT;
                PH_COUNT: phase_next = (cmd.list_byte == '0) ? PH_HIGH : PH_DATA;
                PH_DATA:  phase_next = (remaining_reg == 8'd1) ? PH_HIGH : PH_DATA;
                default:  phase_next = PH_HIGH;
            endcase
        end
    end

    // Header fields and address counter
    always_comb
    begin
        addr_hi_next   = addr_hi_reg;
        cur_addr_next  = cur_addr_reg;
        remaining_next = remaining_reg;
        if (list_step)
        begin
            case (phase_reg)
                PH_HIGH:  addr_hi_next = cmd.list_byte;
                PH_LOW:   cur_addr_next = {addr_hi_reg, cmd.list_byte};
                PH_COUNT:
                begin
                    if (cmd.list_byte != '0)
                    begin
                        remaining_next = cmd.list_byte;
                    end
                end
                PH_DATA:
                begin
                    cur_addr_next  = cur_addr_reg + 1'b1;
                    remaining_next = remaining_reg - 1'b1;
                end
                default:  addr_hi_next = addr_hi_reg;
            endcase
        end
    end

    // Classify the transfer into a job for the back end
    always_comb
    begin
        push             = 1'b0;
        push_job.op      = OP_END;
        push_job.address = cur_addr_reg;
        push_job.data    = cmd.list_byte;
        if (accept && (cmd.command == CMD_READ))
        begin
            push             = 1'b1;
            push_job.op      = (panel_format == FMT_SHORT) ? OP_RD1 : OP_RD3;
            push_job.address = cmd.read_address;
        end
        else if (list_step)
        begin
            case (phase_reg)
                PH_COUNT:
                begin
                    if (cmd.list_byte == '0)
                    begin
                        if (cur_addr_reg == '0)
                        begin
                            push        = 1'b1;
                            push_job.op = OP_END;
                        end
                        else if (panel_format == FMT_LONG)
                        begin
                            push        = 1'b1;
                            push_job.op = OP_SEL;
                        end
                    end
                end
                PH_DATA:
                begin
                    push        = 1'b1;
                    push_job.op = (panel_format == FMT_SHORT) ? OP_WR1 : OP_WR3;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HIGH;
            addr_hi_reg   <= '0;
            cur_addr_reg  <= '0;
            remaining_reg <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            addr_hi_reg   <= addr_hi_next;
            cur_addr_reg  <= cur_addr_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule

[sv/pinit_back.sv]
module pinit_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pinit_pkg::q_status_t q_status,
    input  pinit_pkg::job_t      pop_job,
    output logic                 pop,
    output logic                 res_valid,
    input  logic                 res_ready,
    output pinit_pkg::res_item_t res
);
    import pinit_pkg::*;

    job_t       job_reg, job_next;
    logic       job_valid_reg, job_valid_next;
    logic [1:0] idx_reg, idx_next;
    res_item_t  out_reg, out_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_load;
    logic       emit;
    logic       job_done;

    assign out_load = !out_valid_reg || res_ready;
    assign emit     = job_valid_reg && out_load;
    assign job_done = emit && (idx_reg == job_last_index(job_reg.op));
    // Fetch the next job in the cycle that the current one sends its last frame
    assign pop      = q_status.not_empty && (!job_valid_reg || job_done);

    always_comb
    begin
        job_next       = pop ? pop_job : job_reg;
        job_valid_next = pop ? 1'b1 : (job_done ? 1'b0 : job_valid_reg);
        idx_next       = pop ? 2'd0 : (emit ? idx_reg + 1'b1 : idx_reg);
        out_next       = emit ? build_frame(job_reg, idx_reg) : out_reg;
        out_valid_next = emit ? 1'b1 : (res_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        out_reg <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

[sv/panel_init_list_to_spi_frames_top.sv]
// The first frame of an item passes the job queue, the job register and the output
//   register before it is offered; frames leave one per cycle while res_ready is high.
//   A job yields one, two or three outputs; items that make no job stay in the parser.
// A four-entry job queue lets the parser keep taking items while frames drain.
// Reset (rst_n, asynchronous, active low) empties the queue and output stage,
//   returns the parser to the address high byte and selects panel format 0.
module panel_init_list_to_spi_frames_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [pinit_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [pinit_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [pinit_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                   pready,
    // command channel
    input  logic                                   cmd_valid,
    output logic                                   cmd_ready,
    input  pinit_pkg::cmd_item_t                   cmd,
    // frame channel
    output logic                                   res_valid,
    input  logic                                   res_ready,
    output pinit_pkg::res_item_t                   res
);
    import pinit_pkg::*;

    logic      format_reg, format_next;
    logic      cfg_write;
    logic      cfg_hit;
    logic      push;
    job_t      push_job;
    logic      pop;
    job_t      pop_job;
    q_status_t q_status;

    // Register file: a single format bit; writes complete in the access phase
    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[CFG_ADDR_W-1:2] == REG_PANEL_FORMAT);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        format_next = format_reg;
        if (cfg_write && cfg_hit)
        begin
            format_next = pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (cfg_hit)
        begin
            prdata = {{(APB_DATA_W-1){1'b0}}, format_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= FMT_LONG;
        end
        else
        begin
            format_reg <= format_next;
        end
    end

    // Front end: parse list bytes, turn each transfer into at most one job
    pinit_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .panel_format (format_reg),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .q_status     (q_status),
        .push         (push),
        .push_job     (push_job)
    );

    // Decouple parsing from frame generation
    pinit_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    // Back end: expand each job into its frames, one per cycle while res_ready allows
    pinit_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_job   (pop_job),
        .pop       (pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // End marker carries no frame and closes its item
    a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.list_end |-> res.last && !res.frame_valid)
        else $error("end marker with frame or without last");

    // Reply capture only ever on the final frame, with the fill byte
    a_capture_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.capture_reply |-> res.last && (res.frame_second == READ_FILL))
        else $error("capture on wrong frame");

    // Frames of one job follow each other with no bubble
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res.last |=> res_valid)
        else $error("gap inside a multi-frame job");

endmodule
